FILE: rtl/ksp_bfs_pkg.sv
// ----------------------------------------------------------------------------
// ksp_bfs_pkg: shared types and constants for the knight shortest path search
// Holds the sequencer state type and the knight move offset tables.
// ----------------------------------------------------------------------------
package ksp_bfs_pkg;

  // number of knight moves tried from each cell
  localparam int MOVES = 8;
  // width of the move index and of one move offset
  localparam int MW    = 3;

  // column and row offsets of the eight knight moves
  localparam logic signed [MW-1:0] MOVE_DX [MOVES] = '{
    3'sd2, 3'sd2, -3'sd2, -3'sd2, 3'sd1, 3'sd1, -3'sd1, -3'sd1
  };
  localparam logic signed [MW-1:0] MOVE_DY [MOVES] = '{
    -3'sd1, 3'sd1, 3'sd1, -3'sd1, 3'sd2, -3'sd2, 3'sd2, -3'sd2
  };

  // sequencer states
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_FETCH,
    SEQ_CHECK,
    SEQ_MOVE
  } seq_state_t;

endpackage

FILE: rtl/knight_shortest_path_bfs_top.sv
// ----------------------------------------------------------------------------
// knight_shortest_path_bfs_top: knight shortest path by breadth-first search
// Takes a source and a destination square and returns the fewest knight
// moves between them, with a flag when the destination cannot be reached.
// ----------------------------------------------------------------------------
//
//  channel   ports                                    handshake
//  --------  ---------------------------------------  -------------------------
//  input     in_src_x in_src_y in_dest_x in_dest_y    start & !busy
//  result    out_steps out_reachable                  out_valid, one cycle
//
//  One item holds busy for a seed step, then per cell taken off the queue a
//  queue read, a compare and eight serial move checks, up to an empty-queue
//  step or the compare that finds the destination; an off-board square ends
//  it at the seed step. The result strobe comes in the first cycle with busy low.
//  Reset clears the sequencer, the queue pointers and the visited map; the
//  receiver cannot stall the one-cycle result.
//
module knight_shortest_path_bfs_top #(
  parameter int BOARD_SIZE  = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_src_x,
  input  logic [2:0] in_src_y,
  input  logic [2:0] in_dest_x,
  input  logic [2:0] in_dest_y,
  output logic       out_valid,
  output logic [5:0] out_steps,
  output logic       out_reachable
);

  // derived sizes
  localparam int CELLS = BOARD_SIZE * BOARD_SIZE;
  localparam int CW    = (BOARD_SIZE > 1) ? $clog2(BOARD_SIZE) : 1;
  localparam int NW    = CW + 2;
  localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DW    = $clog2(CELLS) + 1;
  localparam int EW    = 2 * CW + DW;
  localparam int QI    = $clog2(QUEUE_DEPTH);
  localparam int CTW   = $clog2(QUEUE_DEPTH + 1);

  // sequencer and control registers
  ksp_bfs_pkg::seq_state_t state_r, state_nxt;
  logic [2:0]        src_x_r, src_x_nxt;
  logic [2:0]        src_y_r, src_y_nxt;
  logic [2:0]        dst_x_r, dst_x_nxt;
  logic [2:0]        dst_y_r, dst_y_nxt;
  logic [QI-1:0]     head_r, head_nxt;
  logic [QI-1:0]     tail_r, tail_nxt;
  logic [CTW-1:0]    count_r, count_nxt;
  logic [ksp_bfs_pkg::MW-1:0] k_r, k_nxt;
  logic [CELLS-1:0]  visited_r, visited_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [5:0]        out_steps_r, out_steps_nxt;
  logic              out_reachable_r, out_reachable_nxt;

  // queue memory and its ports
  logic [EW-1:0]     queue_mem [QUEUE_DEPTH];
  logic [EW-1:0]     q_rdata_r;
  logic              q_we;
  logic              q_re;
  logic [QI-1:0]     q_waddr;
  logic [EW-1:0]     q_wdata;

  // fields of the cell taken off the queue
  logic [CW-1:0]     cur_x;
  logic [CW-1:0]     cur_y;
  logic [DW-1:0]     cur_dist;
  logic [DW+5:0]     dist_ext;
  logic [5:0]        steps_sat;
  logic              at_dest;

  // neighbor adder and board checks
  logic signed [NW-1:0] nb_x;
  logic signed [NW-1:0] nb_y;
  logic                 nb_on_board;
  logic                 src_on_board;
  logic                 dst_on_board;
  logic [CW-1:0]        cell_x;
  logic [CW-1:0]        cell_y;
  logic [IW-1:0]        cell_idx;
  logic                 nb_free;
  logic                 q_has_room;

  // split the registered queue entry
  assign cur_x    = q_rdata_r[EW-1 -: CW];
  assign cur_y    = q_rdata_r[EW-1-CW -: CW];
  assign cur_dist = q_rdata_r[DW-1:0];
  assign dist_ext = {6'd0, cur_dist};
  assign steps_sat = (dist_ext > (DW+6)'(63)) ? 6'd63 : dist_ext[5:0];
  assign at_dest  = (5'(cur_x) == 5'(dst_x_r)) && (5'(cur_y) == 5'(dst_y_r));

  // check the query squares against the board
  assign src_on_board = ({2'b00, src_x_r} < 5'(BOARD_SIZE)) &&
                        ({2'b00, src_y_r} < 5'(BOARD_SIZE));
  assign dst_on_board = ({2'b00, dst_x_r} < 5'(BOARD_SIZE)) &&
                        ({2'b00, dst_y_r} < 5'(BOARD_SIZE));

  // add the current move offset to the cell under expansion
  assign nb_x = $signed({2'b00, cur_x}) + NW'(ksp_bfs_pkg::MOVE_DX[k_r]);
  assign nb_y = $signed({2'b00, cur_y}) + NW'(ksp_bfs_pkg::MOVE_DY[k_r]);
  assign nb_on_board = !nb_x[NW-1] && !nb_y[NW-1] &&
                       (nb_x < $signed(NW'(BOARD_SIZE))) &&
                       (nb_y < $signed(NW'(BOARD_SIZE)));

  // pick the cell whose visited bit is looked up or set
  always_comb begin
    if (state_r == ksp_bfs_pkg::SEQ_START) begin
      cell_x = CW'(src_x_r);
      cell_y = CW'(src_y_r);
    end else begin
      cell_x = nb_x[CW-1:0];
      cell_y = nb_y[CW-1:0];
    end
  end

  assign cell_idx   = IW'(int'(cell_y) * BOARD_SIZE + int'(cell_x));
  assign nb_free    = nb_on_board && !visited_r[cell_idx];
  assign q_has_room = count_r < CTW'(QUEUE_DEPTH);

  // next state and datapath control
  always_comb begin
    state_nxt         = state_r;
    src_x_nxt         = src_x_r;
    src_y_nxt         = src_y_r;
    dst_x_nxt         = dst_x_r;
    dst_y_nxt         = dst_y_r;
    head_nxt          = head_r;
    tail_nxt          = tail_r;
    count_nxt         = count_r;
    k_nxt             = k_r;
    visited_nxt       = visited_r;
    out_valid_nxt     = 1'b0;
    out_steps_nxt     = out_steps_r;
    out_reachable_nxt = out_reachable_r;
    q_we              = 1'b0;
    q_re              = 1'b0;
    q_waddr           = tail_r;
    q_wdata           = {cell_x, cell_y, cur_dist + 1'b1};

    case (state_r)
      ksp_bfs_pkg::SEQ_IDLE: begin
        // take a new item
        if (start) begin
          src_x_nxt = in_src_x;
          src_y_nxt = in_src_y;
          dst_x_nxt = in_dest_x;
          dst_y_nxt = in_dest_y;
          state_nxt = ksp_bfs_pkg::SEQ_START;
        end
      end

      ksp_bfs_pkg::SEQ_START: begin
        // clear the search and queue the source
        head_nxt    = '0;
        visited_nxt = '0;
        if (src_on_board && dst_on_board) begin
          q_we                  = 1'b1;
          q_waddr               = '0;
          q_wdata               = {cell_x, cell_y, {DW{1'b0}}};
          visited_nxt[cell_idx] = 1'b1;
          tail_nxt              = QI'(1);
          count_nxt             = CTW'(1);
          state_nxt             = ksp_bfs_pkg::SEQ_FETCH;
        end else begin
          tail_nxt          = '0;
          count_nxt         = '0;
          out_valid_nxt     = 1'b1;
          out_steps_nxt     = 6'd0;
          out_reachable_nxt = 1'b0;
          state_nxt         = ksp_bfs_pkg::SEQ_IDLE;
        end
      end

      ksp_bfs_pkg::SEQ_FETCH: begin
        // dequeue the next cell, or report unreachable when empty
        if (count_r == '0) begin
          out_valid_nxt     = 1'b1;
          out_steps_nxt     = 6'd0;
          out_reachable_nxt = 1'b0;
          state_nxt         = ksp_bfs_pkg::SEQ_IDLE;
        end else begin
          q_re      = 1'b1;
          head_nxt  = (head_r == QI'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt = count_r - 1'b1;
          state_nxt = ksp_bfs_pkg::SEQ_CHECK;
        end
      end

      ksp_bfs_pkg::SEQ_CHECK: begin
        // stop at the destination, else start trying moves
        if (at_dest) begin
          out_valid_nxt     = 1'b1;
          out_steps_nxt     = steps_sat;
          out_reachable_nxt = 1'b1;
          state_nxt         = ksp_bfs_pkg::SEQ_IDLE;
        end else begin
          k_nxt     = '0;
          state_nxt = ksp_bfs_pkg::SEQ_MOVE;
        end
      end

      ksp_bfs_pkg::SEQ_MOVE: begin
        // check one move per cycle, queueing its neighbor if free and the queue has room
        if (nb_free && q_has_room) begin
          q_we                  = 1'b1;
          visited_nxt[cell_idx] = 1'b1;
          tail_nxt  = (tail_r == QI'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          count_nxt = count_r + 1'b1;
        end
        k_nxt = k_r + 1'b1;
        if (k_r == ksp_bfs_pkg::MW'(ksp_bfs_pkg::MOVES - 1)) begin
          state_nxt = ksp_bfs_pkg::SEQ_FETCH;
        end
      end

      default: begin
        state_nxt = ksp_bfs_pkg::SEQ_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ksp_bfs_pkg::SEQ_IDLE;
      head_r          <= '0;
      tail_r          <= '0;
      count_r         <= '0;
      k_r             <= '0;
      visited_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      head_r          <= head_nxt;
      tail_r          <= tail_nxt;
      count_r         <= count_nxt;
      k_r             <= k_nxt;
      visited_r       <= visited_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src_x_r         <= src_x_nxt;
    src_y_r         <= src_y_nxt;
    dst_x_r         <= dst_x_nxt;
    dst_y_r         <= dst_y_nxt;
    out_steps_r     <= out_steps_nxt;
    out_reachable_r <= out_reachable_nxt;
  end

  // queue memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rdata_r <= queue_mem[head_r];
    end
  end

  // drive the ports
  assign busy          = (state_r != ksp_bfs_pkg::SEQ_IDLE);
  assign out_valid     = out_valid_r;
  assign out_steps     = out_steps_r;
  assign out_reachable = out_reachable_r;

endmodule

FILE: test/tb_knight_shortest_path_bfs_top.sv
// ----------------------------------------------------------------------------
// tb_knight_shortest_path_bfs_top: self-checking bench for the knight search
// Drives source and destination squares through the start/busy handshake,
// predicts the fewest knight moves with a local breadth-first search, and
// compares every result strobe against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb_knight_shortest_path_bfs_top;

  localparam int BOARD      = 8;
  localparam int CELLS      = BOARD * BOARD;
  localparam int QDEPTH     = 64;
  localparam int N_RANDOM   = 1000;
  localparam int N_CALM     = 150;
  localparam int DRAIN_WAIT = 700;
  localparam int LIMIT      = 3000000;

  // expected result of one query
  typedef struct packed {
    logic [5:0] steps;
    logic       reachable;
  } hop_result_t;

  // predicts each query and matches results against the oldest prediction
  class hop_count_board;
    hop_result_t hops_due[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    // breadth-first search over the knight moves, marking cells when queued
    function void knight_hops(input int sx, input int sy, input int dx,
                              input int dy, output hop_result_t res);
      int  move_dx [8];
      int  move_dy [8];
      bit  seen [CELLS];
      int  qx [QDEPTH];
      int  qy [QDEPTH];
      int  qd [QDEPTH];
      int  head, tail, count;
      int  cx, cy, cd, nx, ny;
      move_dx = '{2, 2, -2, -2, 1, 1, -1, -1};
      move_dy = '{-1, 1, 1, -1, 2, -2, 2, -2};
      res = '0;
      head = 0;
      tail = 0;
      count = 0;
      foreach (seen[i]) seen[i] = 1'b0;
      if (sx < BOARD && sy < BOARD && dx < BOARD && dy < BOARD) begin
        qx[0] = sx;
        qy[0] = sy;
        qd[0] = 0;
        seen[sy * BOARD + sx] = 1'b1;
        tail = 1;
        count = 1;
        while (count > 0 && !res.reachable) begin
          cx = qx[head];
          cy = qy[head];
          cd = qd[head];
          head = (head + 1) % QDEPTH;
          count--;
          if (cx == dx && cy == dy) begin
            res.steps = (cd > 63) ? 6'd63 : 6'(cd);
            res.reachable = 1'b1;
          end else begin
            for (int k = 0; k < 8; k++) begin
              nx = cx + move_dx[k];
              ny = cy + move_dy[k];
              // a full queue drops the cell and leaves it unvisited
              if (nx >= 0 && ny >= 0 && nx < BOARD && ny < BOARD &&
                  !seen[ny * BOARD + nx] && count < QDEPTH) begin
                qx[tail] = nx;
                qy[tail] = ny;
                qd[tail] = cd + 1;
                seen[ny * BOARD + nx] = 1'b1;
                tail = (tail + 1) % QDEPTH;
                count++;
              end
            end
          end
        end
      end
    endfunction

    // record an accepted query
    function void note_query(input logic [2:0] sx, input logic [2:0] sy,
                             input logic [2:0] dx, input logic [2:0] dy);
      hop_result_t res;
      knight_hops(int'(sx), int'(sy), int'(dx), int'(dy), res);
      hops_due.push_back(res);
    endfunction

    // compare one result strobe with the oldest prediction
    function void check_result(input logic [5:0] steps, input logic reachable);
      hop_result_t want;
      if (hops_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual steps %0d reachable %0d",
                 $time, steps, reachable);
        mismatches++;
      end else begin
        want = hops_due.pop_front();
        if (steps !== want.steps) begin
          $display("%0t: steps mismatch, expected %0d, actual %0d",
                   $time, want.steps, steps);
          mismatches++;
        end
        if (reachable !== want.reachable) begin
          $display("%0t: reachable mismatch, expected %0d, actual %0d",
                   $time, want.reachable, reachable);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return hops_due.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [2:0] in_src_x;
  logic [2:0] in_src_y;
  logic [2:0] in_dest_x;
  logic [2:0] in_dest_y;
  logic       out_valid;
  logic [5:0] out_steps;
  logic       out_reachable;

  hop_count_board board;
  int             n_accepted;
  int             cycle_count;

  knight_shortest_path_bfs_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_src_x     (in_src_x),
    .in_src_y     (in_src_y),
    .in_dest_x    (in_dest_x),
    .in_dest_y    (in_dest_y),
    .out_valid    (out_valid),
    .out_steps    (out_steps),
    .out_reachable(out_reachable)
  );

  // free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        board.note_query(in_src_x, in_src_y, in_dest_x, in_dest_y);
        n_accepted++;
      end
      if (out_valid) begin
        board.check_result(out_steps, out_reachable);
      end
    end
  end

  // end the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // present one query at the falling edge and hold it until accepted
  task automatic send_query(input logic [2:0] sx, input logic [2:0] sy,
                            input logic [2:0] dx, input logic [2:0] dy,
                            input bit allow_gap);
    int prev_accepted;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_src_x      = sx;
    in_src_y      = sy;
    in_dest_x     = dx;
    in_dest_y     = dy;
    start         = 1'b1;
    prev_accepted = n_accepted;
    do @(negedge clk); while (n_accepted == prev_accepted);
  endtask

  initial begin
    logic [2:0] sx, sy, dx, dy;
    board       = new();
    n_accepted  = 0;
    cycle_count = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_src_x    = '0;
    in_src_y    = '0;
    in_dest_x   = '0;
    in_dest_y   = '0;

    // hold reset, release on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: same square, corners, one hop, the corner-to-diagonal case
    send_query(3'd0, 3'd0, 3'd0, 3'd0, 1'b0);
    send_query(3'd7, 3'd7, 3'd7, 3'd7, 1'b0);
    send_query(3'd3, 3'd4, 3'd3, 3'd4, 1'b1);
    send_query(3'd0, 3'd0, 3'd7, 3'd7, 1'b0);
    send_query(3'd7, 3'd7, 3'd0, 3'd0, 1'b1);
    send_query(3'd0, 3'd7, 3'd7, 3'd0, 1'b0);
    send_query(3'd7, 3'd0, 3'd0, 3'd7, 1'b1);
    send_query(3'd0, 3'd0, 3'd1, 3'd1, 1'b0);
    send_query(3'd7, 3'd7, 3'd6, 3'd6, 1'b0);
    send_query(3'd0, 3'd0, 3'd1, 3'd2, 1'b1);
    send_query(3'd0, 3'd0, 3'd2, 3'd1, 1'b0);
    send_query(3'd0, 3'd0, 3'd7, 3'd0, 1'b1);
    send_query(3'd0, 3'd0, 3'd0, 3'd1, 1'b0);
    send_query(3'd4, 3'd4, 3'd5, 3'd5, 1'b0);
    send_query(3'd3, 3'd3, 3'd4, 3'd3, 1'b1);
    send_query(3'd5, 3'd2, 3'd2, 3'd5, 1'b0);
    send_query(3'd1, 3'd6, 3'd6, 3'd1, 1'b1);
    send_query(3'd7, 3'd0, 3'd6, 3'd2, 1'b0);

    // random queries, gaps only before the final calm stretch
    for (int i = 0; i < N_RANDOM; i++) begin
      sx = 3'($urandom_range(0, 7));
      sy = 3'($urandom_range(0, 7));
      dx = 3'($urandom_range(0, 7));
      dy = 3'($urandom_range(0, 7));
      // now and then ask for the source square itself
      if ($urandom_range(0, 15) == 0) begin
        dx = sx;
        dy = sy;
      end
      send_query(sx, sy, dx, dy, i < N_RANDOM - N_CALM);
    end
    start = 1'b0;

    // drain outstanding results, then let the block settle
    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
